[hdl/brb_pkg.sv]
// Shared types and field widths for the byte ring buffer.
package brb_pkg;

  localparam int DATA_W = 8;
  localparam int CNT_W  = 7;
  localparam int USED_W = 10;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_t;

endpackage

[hdl/brb_store.sv]
// Byte storage: one write port and one registered read port.
module brb_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [brb_pkg::DATA_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [brb_pkg::DATA_W-1:0] rdata
);

  logic [brb_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // The read register holds its value while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/byte_ring_buffer.sv]
// Top level of the byte ring buffer: command decode, read sequencer and output register.
//
//   channel | dir | tdata (low bit up)                      | tuser | tlast
//   s_*     | in  | data_in[7:0], request_count[14:8]       | cmd   | -
//   m_*     | out | data_out[7:0], granted[14:8], used[24:15] | ok  | last
//
// An enqueue, an empty read or a zero-count read gives a single result from the command cycle.
// A dequeue or peek item that moves n bytes has the command cycle, one read of the store per
// cycle on its single read port while the output is not stalled, and the last byte's output load.
// The next item is taken once the last byte has left the store's read register.
// Reset clears the indices and the occupancy; the store itself is not cleared.
// A stalled output holds the read pipeline in place; no item is lost or repeated.
module byte_ring_buffer #(
  parameter int DEPTH   = 1024,
  parameter int MAX_REQ = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // data_in[7:0], request_count[14:8], zero pad
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // data_out[7:0], granted[14:8], used[24:15], zero pad
  output logic [0:0]  m_tuser,   // ok[0]
  output logic        m_tlast
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CW    = IDX_W + brb_pkg::CNT_W;
  localparam logic [IDX_W-1:0] DEPTH_M1 = IDX_W'(DEPTH - 1);
  localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W+1)'(DEPTH);
  localparam logic [brb_pkg::CNT_W-1:0] MAX_REQ_C = brb_pkg::CNT_W'(MAX_REQ);

  typedef enum logic {
    IDLE,
    READ
  } state_t;

  state_t state;

  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] count;
  logic [IDX_W-1:0] raddr;
  logic [brb_pkg::CNT_W-1:0] rem;
  logic [brb_pkg::CNT_W-1:0] burst_n;
  logic [IDX_W-1:0] burst_used;

  logic p;
  logic p_last;
  logic [brb_pkg::DATA_W-1:0] rd_q;

  logic                       o_ok;
  logic [brb_pkg::DATA_W-1:0] o_data;
  logic [brb_pkg::CNT_W-1:0]  o_granted;
  logic [brb_pkg::USED_W-1:0] o_used;

  brb_pkg::cmd_t cmd;
  logic [brb_pkg::DATA_W-1:0] data_in;
  logic [brb_pkg::CNT_W-1:0]  req_in;
  logic [brb_pkg::CNT_W-1:0]  sat_req;
  logic [CW-1:0] sat_w;
  logic [CW-1:0] held_w;
  logic [CW-1:0] n_w;
  logic [brb_pkg::CNT_W-1:0] n;
  logic [IDX_W:0] rd_sum;
  logic [IDX_W:0] rd_sum_wrap;
  logic [IDX_W-1:0] rd_idx_adv;
  logic [IDX_W-1:0] wr_idx_inc;
  logic [IDX_W-1:0] raddr_inc;
  logic [IDX_W-1:0] count_inc;
  logic [IDX_W-1:0] count_after;

  logic full;
  logic empty;
  logic out_free;
  logic out_load;
  logic imm_res;
  logic rd_en;
  logic s_hs;
  logic we;

  function automatic logic [brb_pkg::USED_W-1:0] to_used(input logic [IDX_W-1:0] v);
    logic [IDX_W+brb_pkg::USED_W-1:0] w;
    w = {{brb_pkg::USED_W{1'b0}}, v};
    return w[brb_pkg::USED_W-1:0];
  endfunction

  assign cmd     = brb_pkg::cmd_t'(s_tuser);
  assign data_in = s_tdata[7:0];
  assign req_in  = s_tdata[14:8];

  assign full  = (count == DEPTH_M1);
  assign empty = (count == '0);

  assign sat_req = (req_in > MAX_REQ_C) ? MAX_REQ_C : req_in;
  assign sat_w   = CW'(sat_req);
  assign held_w  = CW'(count);
  // When the count wins, the occupancy is at most MAX_REQ and fits the grant width.
  assign n_w     = (sat_w < held_w) ? sat_w : held_w;
  assign n       = n_w[brb_pkg::CNT_W-1:0];

  // The grant never exceeds the occupancy, so it is below DEPTH.
  assign rd_sum      = {1'b0, rd_idx} + (IDX_W+1)'(n);
  assign rd_sum_wrap = rd_sum - DEPTH_X;
  assign rd_idx_adv  = (rd_sum >= DEPTH_X) ? rd_sum_wrap[IDX_W-1:0] : rd_sum[IDX_W-1:0];

  assign wr_idx_inc  = (wr_idx == DEPTH_M1) ? '0 : wr_idx + 1'b1;
  assign raddr_inc   = (raddr == DEPTH_M1) ? '0 : raddr + 1'b1;
  assign count_inc   = count + 1'b1;
  assign count_after = count - IDX_W'(n);

  assign out_free = !m_tvalid || m_tready;
  assign out_load = p && out_free;
  assign rd_en    = (state == READ) && (!p || out_free);
  assign s_tready = (state == IDLE) && !p && out_free;
  assign s_hs     = s_tvalid && s_tready;
  assign we       = s_hs && (cmd == brb_pkg::CMD_ENQ) && !full;
  // Items answered straight from the command cycle with a single result.
  assign imm_res  = s_hs && ((cmd == brb_pkg::CMD_ENQ) ||
                    ((cmd inside {brb_pkg::CMD_DEQ, brb_pkg::CMD_PEEK}) &&
                     (empty || n == '0)));

  brb_store #(
    .DEPTH (DEPTH),
    .AW    (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (wr_idx),
    .wdata (data_in),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rd_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
      p        <= 1'b0;
      wr_idx   <= '0;
      rd_idx   <= '0;
      count    <= '0;
      rem      <= '0;
    end else begin
      m_tvalid <= out_load || imm_res || (m_tvalid && !m_tready);

      // Move a byte from the store's read register into the output register.
      if (out_load) begin
        o_ok      <= 1'b1;
        o_data    <= rd_q;
        o_granted <= burst_n;
        m_tlast   <= p_last;
        o_used    <= to_used(burst_used);
      end

      if (rd_en) begin
        p      <= 1'b1;
        p_last <= (rem == brb_pkg::CNT_W'(1));
      end else if (out_load) begin
        p <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (s_hs) begin
            unique case (cmd) inside
              brb_pkg::CMD_ENQ: begin
                o_data   <= '0;
                m_tlast  <= 1'b1;
                if (full) begin
                  o_ok      <= 1'b0;
                  o_granted <= '0;
                  o_used    <= to_used(count);
                end else begin
                  o_ok      <= 1'b1;
                  o_granted <= brb_pkg::CNT_W'(1);
                  o_used    <= to_used(count_inc);
                  wr_idx    <= wr_idx_inc;
                  count     <= count_inc;
                end
              end
              brb_pkg::CMD_DEQ, brb_pkg::CMD_PEEK: begin
                if (empty || n == '0) begin
                  o_ok      <= !empty;
                  o_data    <= '0;
                  o_granted <= '0;
                  m_tlast   <= 1'b1;
                  o_used    <= to_used(count);
                end else begin
                  burst_n <= n;
                  raddr   <= rd_idx;
                  rem     <= n;
                  state   <= READ;
                  if (cmd == brb_pkg::CMD_DEQ) begin
                    burst_used <= count_after;
                    rd_idx     <= rd_idx_adv;
                    count      <= count_after;
                  end else begin
                    burst_used <= count;
                  end
                end
              end
              default: begin
                // The reserved command is taken and dropped without a result.
              end
            endcase
          end
        end
        READ: begin
          if (rd_en) begin
            raddr <= raddr_inc;
            rem   <= rem - 1'b1;
            if (rem == brb_pkg::CNT_W'(1)) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {7'b0, o_used, o_granted, o_data};
  assign m_tuser = o_ok;

  // The occupancy register always agrees with the distance between the indices.
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, wr_idx} + ((wr_idx < rd_idx) ? DEPTH_X : '0) - {1'b0, rd_idx})
      == {1'b0, count})
    else $error("occupancy disagrees with the ring indices");

  // A byte held in the read register stays put while the output is stalled.
  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    (p && !out_free) |=> (p && $stable(p_last) && $stable(rd_q)))
    else $error("byte in the read register changed under a stall");

  // The sequencer never sits in the read state with nothing left to issue.
  a_read_rem: assert property (@(posedge clk) disable iff (rst)
    (state == READ) |-> (rem != '0))
    else $error("read sequencer active with no bytes left");

  // Issuing the final read of a burst returns the sequencer to idle.
  a_read_end: assert property (@(posedge clk) disable iff (rst)
    (rd_en && rem == brb_pkg::CNT_W'(1)) |=> (state == IDLE && p && p_last))
    else $error("burst did not close after its final read");

endmodule

[test/brb_checker.sv]
// Checker for the byte ring buffer: predicts every result item and compares it on arrival.
`timescale 1ns / 100ps

module brb_checker #(
  parameter int DEPTH   = 1024,
  parameter int MAX_REQ = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // data_in[7:0], request_count[14:8], zero pad
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // data_out[7:0], granted[14:8], used[24:15], zero pad
  input  logic [0:0]  m_tuser,   // ok[0]
  input  logic        m_tlast,
  output int          errors,
  output int          results_seen,
  output int          pending
);

  typedef struct {
    logic                       ok;
    logic [brb_pkg::DATA_W-1:0] data;
    logic [brb_pkg::CNT_W-1:0]  granted;
    logic                       last;
    logic [brb_pkg::USED_W-1:0] used;
  } ring_result_t;

  logic [brb_pkg::DATA_W-1:0] shadow_bytes [DEPTH];
  int                wr_slot;
  int                rd_slot;
  ring_result_t      due_results [$];

  initial begin
    errors       = 0;
    results_seen = 0;
    pending      = 0;
    wr_slot      = 0;
    rd_slot      = 0;
  end

  function automatic void queue_result(input logic ok,
                                       input logic [brb_pkg::DATA_W-1:0] data,
                                       input int granted, input logic last, input int used);
    ring_result_t r;
    r.ok      = ok;
    r.data    = data;
    r.granted = granted[brb_pkg::CNT_W-1:0];
    r.last    = last;
    r.used    = used[brb_pkg::USED_W-1:0];
    due_results = {due_results, r};
  endfunction

  // Works out the results of one accepted item and advances the shadow indices.
  function automatic void predict_ring_access(input logic [1:0] cmd,
                                              input logic [brb_pkg::DATA_W-1:0] data_in,
                                              input logic [brb_pkg::CNT_W-1:0] want);
    int held;
    int n;
    int after;
    int i;
    held = (wr_slot + DEPTH - rd_slot) % DEPTH;
    case (cmd)
      brb_pkg::CMD_ENQ: begin
        if (held >= DEPTH - 1) begin
          queue_result(1'b0, '0, 0, 1'b1, held);
        end else begin
          shadow_bytes[wr_slot] = data_in;
          wr_slot = (wr_slot + 1) % DEPTH;
          queue_result(1'b1, '0, 1, 1'b1, held + 1);
        end
      end
      brb_pkg::CMD_DEQ, brb_pkg::CMD_PEEK: begin
        if (held == 0) begin
          queue_result(1'b0, '0, 0, 1'b1, 0);
        end else begin
          n = (int'(want) > MAX_REQ) ? MAX_REQ : int'(want);
          if (n > held) n = held;
          after = (cmd == brb_pkg::CMD_DEQ) ? held - n : held;
          if (n == 0) queue_result(1'b1, '0, 0, 1'b1, after);
          for (i = 0; i < n; i++) begin
            queue_result(1'b1, shadow_bytes[(rd_slot + i) % DEPTH], n, i == n - 1, after);
          end
          if (cmd == brb_pkg::CMD_DEQ) rd_slot = (rd_slot + n) % DEPTH;
        end
      end
      default: ;  // the unused command code is dropped by the block
    endcase
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    ring_result_t head;
    if (!rst) begin
      if (s_tvalid && s_tready) predict_ring_access(s_tuser, s_tdata[7:0], s_tdata[14:8]);
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          errors++;
          $error("result item with no prediction waiting: tdata %h tuser %b tlast %b",
                 m_tdata, m_tuser, m_tlast);
        end else begin
          head = due_results.pop_front();
          check_field("ok", head.ok, m_tuser[0]);
          check_field("data_out", head.data, m_tdata[7:0]);
          check_field("granted", head.granted, m_tdata[14:8]);
          check_field("last", head.last, m_tlast);
          check_field("used", head.used, m_tdata[24:15]);
        end
      end
      pending <= due_results.size();
    end
  end

endmodule

[test/testbench.sv]
// Top of the byte ring buffer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

  localparam int DEPTH         = 1024;
  localparam int MAX_REQ       = 64;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS  = 360;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 100;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;

  int errors;
  int results_seen;
  int pending;
  int cycles     = 0;
  int burst_left = 0;
  int sent [4]   = '{0, 0, 0, 0};
  int stall_mode = 0;
  int mode_left  = 0;

  always #2 clk = ~clk;

  byte_ring_buffer #(.DEPTH(DEPTH), .MAX_REQ(MAX_REQ)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  brb_checker #(.DEPTH(DEPTH), .MAX_REQ(MAX_REQ)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .errors(errors), .results_seen(results_seen), .pending(pending)
  );

  // The receiver switches between always ready, half rate and quarter rate.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= $urandom_range(0, 1) == 1;
      default: m_tready <= $urandom_range(0, 3) == 0;
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offers one item and returns once it has been taken; gaps come between bursts.
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] data_in,
                           input logic [6:0] count);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, count, data_in};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    sent[cmd]++;
  endtask

  task automatic hold_until_drained();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Mostly short counts, some up to the cap, a few past it.
  task automatic send_read(input logic [1:0] cmd);
    int sel;
    logic [6:0] count;
    sel = $urandom_range(0, 19);
    if (sel < 12) count = 7'($urandom_range(0, 8));
    else if (sel < 17) count = 7'($urandom_range(9, MAX_REQ));
    else count = 7'($urandom_range(MAX_REQ + 1, 127));
    send_item(cmd, 8'($urandom), count);
  endtask

  initial begin
    int n_items;
    int run_len;
    int i;
    logic [1:0] read_cmd;
    logic [6:0] count;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reads on an empty buffer, an ignored command, then a small fill and reads.
    send_item(brb_pkg::CMD_PEEK, 8'h00, 7'd5);
    send_item(brb_pkg::CMD_DEQ, 8'hFF, 7'd0);
    send_item(brb_pkg::CMD_DEQ, 8'h00, 7'd127);
    send_item(CMD_UNUSED, 8'hC3, 7'd3);
    send_item(brb_pkg::CMD_ENQ, 8'h00, 7'd0);
    send_item(brb_pkg::CMD_ENQ, 8'hFF, 7'd127);
    send_item(brb_pkg::CMD_ENQ, 8'hA5, 7'd0);
    send_item(brb_pkg::CMD_ENQ, 8'h5A, 7'd0);
    send_item(brb_pkg::CMD_ENQ, 8'h01, 7'd0);
    send_item(brb_pkg::CMD_ENQ, 8'h80, 7'd0);
    send_item(brb_pkg::CMD_PEEK, 8'h00, 7'd0);
    send_item(brb_pkg::CMD_DEQ, 8'h00, 7'd0);
    send_item(brb_pkg::CMD_PEEK, 8'h00, 7'd3);
    send_item(brb_pkg::CMD_PEEK, 8'h00, 7'd127);
    send_item(brb_pkg::CMD_DEQ, 8'h00, 7'd2);
    send_item(CMD_UNUSED, 8'h3C, 7'd64);
    send_item(brb_pkg::CMD_DEQ, 8'h00, 7'd100);
    send_item(brb_pkg::CMD_DEQ, 8'h00, 7'd1);
    hold_until_drained();

    // Random part: runs of enqueues followed by reads, with some noise mixed in.
    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          run_len = $urandom_range(1, 24);
          for (i = 0; i < run_len; i++) begin
            send_item(brb_pkg::CMD_ENQ, 8'($urandom), 7'($urandom));
          end
          read_cmd = ($urandom_range(0, 1) == 1) ? brb_pkg::CMD_DEQ : brb_pkg::CMD_PEEK;
          send_read(read_cmd);
          n_items += run_len + 1;
        end
        5, 6: begin
          // Look at the data first, then take the same amount away.
          count = 7'($urandom_range(0, 20));
          send_item(brb_pkg::CMD_PEEK, 8'($urandom), count);
          send_item(brb_pkg::CMD_DEQ, 8'($urandom), count);
          n_items += 2;
        end
        7: begin
          send_read(brb_pkg::CMD_DEQ);
          n_items++;
        end
        default: begin
          read_cmd = 2'($urandom_range(0, 3));
          if (read_cmd == brb_pkg::CMD_ENQ) begin
            send_item(read_cmd, 8'($urandom), 7'($urandom));
          end else if (read_cmd == CMD_UNUSED) begin
            send_item(read_cmd, 8'($urandom), 7'($urandom));
          end else begin
            send_read(read_cmd);
          end
          if (read_cmd != CMD_UNUSED) n_items++;
        end
      endcase
      if (n_items >= RANDOM_ITEMS / 2 && n_items < RANDOM_ITEMS / 2 + 25 &&
          $urandom_range(0, 3) == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d enqueue, %0d dequeue, %0d peek and %0d unused-command items,",
             sent[brb_pkg::CMD_ENQ], sent[brb_pkg::CMD_DEQ], sent[brb_pkg::CMD_PEEK],
             sent[CMD_UNUSED]);
    $display("including reads on an empty buffer and counts past the cap; %0d results compared.",
             results_seen);
    if (pending != 0) $error("%0d predicted result items never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
